/* sv/rcd_pkg.sv */
package rcd_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned KIND_W      = 3;
	localparam int unsigned STATUS_W    = 3;
	localparam int unsigned CAP_W       = 6;
	localparam int unsigned IDX_W       = 5;
	localparam int unsigned MAX_RESULTS = 32;

	localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_REAR   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DISPLAY    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

	localparam logic REG_RESTRICT_MODE = 1'b0;
	localparam logic REG_CAPACITY      = 1'b1;

	localparam logic MODE_INPUT_RESTRICTED  = 1'b0;
	localparam logic MODE_OUTPUT_RESTRICTED = 1'b1;

	typedef enum logic [1:0] {
		OP_STATUS,
		OP_WRITE,
		OP_READ,
		OP_DISPLAY
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t                  op;
		logic [STATUS_W-1:0]      status;
		logic [IDX_W-1:0]         addr;
		logic signed [DATA_W-1:0] data;
		logic [CAP_W-1:0]         count;
		logic [CAP_W-1:0]         cap;
	} cmd_t;

endpackage

/* sv/rcd_front.sv */
module rcd_front
	import rcd_pkg::*;
#(
	parameter int unsigned MAX_CAP = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [DATA_W-1:0] push_value,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CAP_W-1:0]         cfg_data,
	output cmd_t                     cmd
);

	localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(MAX_CAP);
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_RESULTS);

	logic             restrict_mode_q;
	logic [CAP_W-1:0] capacity_q;
	logic [IDX_W-1:0] front_q;
	logic [IDX_W-1:0] rear_q;
	logic [CAP_W-1:0] fill_q;

	logic [CAP_W-1:0] ecap;
	logic [CAP_W-1:0] ecap_m1;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] rear_inc;
	logic [IDX_W-1:0] rear_dec;
	logic [IDX_W-1:0] front_d;
	logic [IDX_W-1:0] rear_d;
	logic [CAP_W-1:0] fill_d;

	always_comb begin
		if (capacity_q == '0) begin
			ecap = CAP_W'(1);
		end else if (capacity_q > CAP_LIMIT) begin
			ecap = CAP_LIMIT;
		end else begin
			ecap = capacity_q;
		end
		ecap_m1   = ecap - CAP_W'(1);
		front_inc = (({1'b0, front_q} + CAP_W'(1)) >= ecap) ? '0 : front_q + IDX_W'(1);
		rear_inc  = (({1'b0, rear_q} + CAP_W'(1)) >= ecap) ? '0 : rear_q + IDX_W'(1);
		front_dec = (front_q == '0) ? ecap_m1[IDX_W-1:0] : front_q - IDX_W'(1);
		rear_dec  = (rear_q == '0) ? ecap_m1[IDX_W-1:0] : rear_q - IDX_W'(1);
	end

	always_comb begin
		cmd.op     = OP_STATUS;
		cmd.status = ST_OK;
		cmd.addr   = '0;
		cmd.data   = push_value;
		cmd.count  = fill_q;
		cmd.cap    = ecap;
		front_d    = front_q;
		rear_d     = rear_q;
		fill_d     = fill_q;
		unique case (kind)
			KIND_PUSH_REAR, KIND_PUSH_FRONT: begin
				if (kind == KIND_PUSH_FRONT && restrict_mode_q == MODE_INPUT_RESTRICTED) begin
					cmd.status = ST_REFUSED;
				end else if (fill_q >= ecap) begin
					cmd.status = ST_OVERFLOW;
				end else begin
					cmd.op = OP_WRITE;
					fill_d = fill_q + CAP_W'(1);
					if (fill_q == '0) begin
						front_d  = '0;
						rear_d   = '0;
						cmd.addr = '0;
					end else if (kind == KIND_PUSH_REAR) begin
						rear_d   = rear_inc;
						cmd.addr = rear_inc;
					end else begin
						front_d  = front_dec;
						cmd.addr = front_dec;
					end
				end
			end
			KIND_POP_FRONT, KIND_POP_REAR: begin
				if (kind == KIND_POP_REAR && restrict_mode_q == MODE_OUTPUT_RESTRICTED) begin
					cmd.status = ST_REFUSED;
				end else if (fill_q == '0) begin
					cmd.status = ST_UNDERFLOW;
				end else begin
					cmd.op = OP_READ;
					fill_d = fill_q - CAP_W'(1);
					if (kind == KIND_POP_FRONT) begin
						cmd.addr = front_q;
						front_d  = front_inc;
					end else begin
						cmd.addr = rear_q;
						rear_d   = rear_dec;
					end
					if (fill_q == CAP_W'(1)) begin
						front_d = '0;
						rear_d  = '0;
					end
				end
			end
			KIND_DISPLAY: begin
				if (fill_q == '0) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.op   = OP_DISPLAY;
					cmd.addr = front_q;
				end
			end
			default: begin
				cmd.status = ST_REFUSED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restrict_mode_q <= MODE_INPUT_RESTRICTED;
			capacity_q      <= CAP_RESET;
			front_q         <= '0;
			rear_q          <= '0;
			fill_q          <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_RESTRICT_MODE) begin
				restrict_mode_q <= cfg_data[0];
			end else begin
				capacity_q <= cfg_data;
				front_q    <= '0;
				rear_q     <= '0;
				fill_q     <= '0;
			end
		end else if (accept) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			fill_q  <= fill_d;
		end
	end

endmodule

/* sv/rcd_cmd_fifo.sv */
module rcd_cmd_fifo
	import rcd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	cmd_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign head  = entries_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("command word pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("command word popped from an empty queue");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue empty after a push");

endmodule

/* sv/rcd_back.sv */
module rcd_back
	import rcd_pkg::*;
#(
	parameter int unsigned MEM_DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic                     cmd_valid,
	output logic                     cmd_pop,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic signed [DATA_W-1:0] data_value,
	output logic                     last
);

	localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic signed [DATA_W-1:0] mem_q [MEM_DEPTH];
	logic signed [DATA_W-1:0] rd_q;

	logic                walk_q;
	logic [IDX_W-1:0]    walk_addr_q;
	logic [CAP_W-1:0]    walk_rem_q;
	logic [CAP_W-1:0]    walk_cap_q;
	logic                done_s1;
	logic [STATUS_W-1:0] status_s1;
	logic                last_s1;
	logic                use_rd_s1;

	logic                rd_en;
	logic                wr_en;
	logic [IDX_W-1:0]    rd_addr;
	logic [IDX_W-1:0]    walk_next;

	always_comb begin
		cmd_pop   = cmd_valid && !walk_q;
		rd_en     = walk_q || (cmd_pop && cmd.op == OP_READ);
		wr_en     = cmd_pop && cmd.op == OP_WRITE;
		rd_addr   = walk_q ? walk_addr_q : cmd.addr;
		walk_next = (({1'b0, walk_addr_q} + CAP_W'(1)) >= walk_cap_q) ? '0
			: walk_addr_q + IDX_W'(1);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[cmd.addr[AW-1:0]] <= cmd.data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q  <= 1'b0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= walk_q || (cmd_pop && cmd.op != OP_DISPLAY);
			if (walk_q) begin
				if (walk_rem_q == CAP_W'(1)) begin
					walk_q <= 1'b0;
				end
			end else if (cmd_pop && cmd.op == OP_DISPLAY) begin
				walk_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (walk_q) begin
			walk_addr_q <= walk_next;
			walk_rem_q  <= walk_rem_q - CAP_W'(1);
			status_s1   <= ST_OK;
			last_s1     <= (walk_rem_q == CAP_W'(1));
			use_rd_s1   <= 1'b1;
		end else if (cmd_pop) begin
			walk_addr_q <= cmd.addr;
			walk_rem_q  <= cmd.count;
			walk_cap_q  <= cmd.cap;
			status_s1   <= cmd.status;
			last_s1     <= 1'b1;
			use_rd_s1   <= (cmd.op == OP_READ);
		end
	end

	assign done       = done_s1;
	assign status     = status_s1;
	assign last       = last_s1;
	assign data_value = use_rd_s1 ? rd_q : '0;

	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q |-> (walk_rem_q != '0))
		else $error("display walk running with no words left");
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s1 && status_s1 != ST_OK) |-> last_s1)
		else $error("error word not marked last");
	a_walk_done: assert property (@(posedge clk) disable iff (!arst_n)
		(walk_q && walk_rem_q == CAP_W'(1)) |=> (done_s1 && last_s1 && !walk_q))
		else $error("display walk did not end on its last word");

endmodule

/* sv/restricted_circular_deque.sv */
// Circular double-ended queue of signed 32-bit words with input- or output-restricted mode.
// An item is taken whenever start is high and busy is low; busy rises only when the two-entry
// command queue between the classifier and the memory side is full. Push, pop, refused and
// error items do not hold the memory side, so a run of them is sustained at one item per
// cycle. When nothing is ahead of it, a result is registered in the command queue and then in
// the memory side's output register before it is on done. A display of n words holds the
// memory side while it walks them, with one read-port access per word, and sends one result per
// cycle. Results are presented for exactly one cycle and cannot be held off by the receiver.
// Configuration writes are meant for an idle block; a capacity write empties the queue.
module restricted_circular_deque
	import rcd_pkg::*;
#(
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [KIND_W-1:0]        kind,
	input  logic signed [DATA_W-1:0] push_value,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [CAP_W-1:0]         cfg_data,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic signed [DATA_W-1:0] data_value,
	output logic                     last
);

	localparam int unsigned MEM_DEPTH = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

	logic accept;
	cmd_t front_cmd;
	cmd_t head_cmd;
	logic fifo_empty;
	logic fifo_full;
	logic fifo_pop;

	assign busy   = fifo_full;
	assign accept = start && !fifo_full;

	rcd_front #(
		.MAX_CAP(MEM_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.push_value(push_value),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (front_cmd)
	);

	rcd_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept),
		.push_cmd(front_cmd),
		.pop     (fifo_pop),
		.head    (head_cmd),
		.empty   (fifo_empty),
		.full    (fifo_full)
	);

	rcd_back #(
		.MEM_DEPTH(MEM_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head_cmd),
		.cmd_valid (!fifo_empty),
		.cmd_pop   (fifo_pop),
		.done      (done),
		.status    (status),
		.data_value(data_value),
		.last      (last)
	);

endmodule

/* bench/restricted_circular_deque_tb.sv */
module restricted_circular_deque_tb;
	import rcd_pkg::*;

	localparam int unsigned DEPTH = 32;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 30;
	localparam int QUIET_PHASE = 5;
	localparam int SETTLE_CYCLES = 3;
	localparam int TAIL_CYCLES = 40;
	localparam logic [KIND_W-1:0] KIND_BAD_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_BAD_HI = 3'd7;

	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] data;
		logic                     last;
	} word_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_act_t;

	typedef struct packed {
		row_act_t                 act;
		logic [KIND_W-1:0]        kind;
		logic                     reg_idx;
		logic signed [DATA_W-1:0] value;
		logic                     typed;
		word_t                    w;
	} row_t;

	localparam word_t NO_WORD = '{ST_OK, 32'sd0, 1'b0};
	localparam int NUM_ROWS = 29;

	// directed walk: empty queue, refusals, extremes, tiny and out-of-range capacities
	localparam row_t PLAN [0:NUM_ROWS-1] = '{
		'{ROW_ITEM, KIND_POP_FRONT,  REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_UNDERFLOW, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_POP_REAR,   REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_UNDERFLOW, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_DISPLAY,    REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_EMPTY, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_PUSH_FRONT, REG_RESTRICT_MODE, 32'sd123, 1'b1, '{ST_REFUSED, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_BAD_LO,     REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_REFUSED, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_BAD_HI,     REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_REFUSED, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_PUSH_REAR, REG_RESTRICT_MODE, 32'sh7fff_ffff, 1'b1,
			'{ST_OK, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_PUSH_REAR, REG_RESTRICT_MODE, 32'sh8000_0000, 1'b1,
			'{ST_OK, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_PUSH_REAR,  REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_OK, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_PUSH_REAR, REG_RESTRICT_MODE, 32'shffff_ffff, 1'b1,
			'{ST_OK, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_DISPLAY,    REG_RESTRICT_MODE, 32'sd0,   1'b0, NO_WORD},
		'{ROW_ITEM, KIND_POP_FRONT, REG_RESTRICT_MODE, 32'sd0, 1'b1,
			'{ST_OK, 32'sh7fff_ffff, 1'b1}},
		'{ROW_ITEM, KIND_POP_REAR, REG_RESTRICT_MODE, 32'sd0, 1'b1,
			'{ST_OK, 32'shffff_ffff, 1'b1}},
		'{ROW_REG,  KIND_PUSH_REAR,  REG_RESTRICT_MODE, 32'sd1,   1'b0, NO_WORD},
		'{ROW_ITEM, KIND_PUSH_FRONT, REG_RESTRICT_MODE, 32'sh5555_5555, 1'b1,
			'{ST_OK, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_POP_REAR,   REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_REFUSED, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_PUSH_REAR, REG_RESTRICT_MODE, 32'shaaaa_aaaa, 1'b1,
			'{ST_OK, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_DISPLAY,    REG_RESTRICT_MODE, 32'sd0,   1'b0, NO_WORD},
		'{ROW_REG,  KIND_PUSH_REAR,  REG_CAPACITY,      32'sd1,   1'b0, NO_WORD},
		'{ROW_ITEM, KIND_PUSH_REAR,  REG_RESTRICT_MODE, 32'sd1,   1'b1, '{ST_OK, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_PUSH_FRONT, REG_RESTRICT_MODE, 32'sd2,   1'b1, '{ST_OVERFLOW, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_POP_FRONT,  REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_OK, 32'sd1, 1'b1}},
		'{ROW_REG,  KIND_PUSH_REAR,  REG_CAPACITY,      32'sd0,   1'b0, NO_WORD},
		'{ROW_ITEM, KIND_PUSH_FRONT, REG_RESTRICT_MODE, 32'sd3,   1'b1, '{ST_OK, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_PUSH_REAR,  REG_RESTRICT_MODE, 32'sd4,   1'b1, '{ST_OVERFLOW, 32'sd0, 1'b1}},
		'{ROW_ITEM, KIND_DISPLAY,    REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_OK, 32'sd3, 1'b1}},
		'{ROW_REG,  KIND_PUSH_REAR,  REG_CAPACITY,      32'sd63,  1'b0, NO_WORD},
		'{ROW_REG,  KIND_PUSH_REAR,  REG_RESTRICT_MODE, 32'sd0,   1'b0, NO_WORD},
		'{ROW_ITEM, KIND_POP_REAR,   REG_RESTRICT_MODE, 32'sd0,   1'b1, '{ST_UNDERFLOW, 32'sd0, 1'b1}}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [KIND_W-1:0]        kind;
	logic signed [DATA_W-1:0] push_value;
	logic                     cfg_we;
	logic                     cfg_index;
	logic [CAP_W-1:0]         cfg_data;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic signed [DATA_W-1:0] data_value;
	logic                     last;

	restricted_circular_deque #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.push_value(push_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.status(status),
		.data_value(data_value),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// deque state as the block should hold it
	logic signed [DATA_W-1:0] ring [DEPTH];
	int unsigned              head;
	int unsigned              tail;
	int unsigned              fill;
	logic                     mode;
	logic [CAP_W-1:0]         cap_reg;

	word_t pending_words [$];
	word_t fresh_words [$];
	int    err_count = 0;
	int    stall_cycles = 0;

	task automatic report_mismatch(input string msg);
		if (err_count < 50)
			$display("mismatch: %s", msg);
		err_count++;
	endtask

	task automatic add_word(input logic [STATUS_W-1:0] st, input logic signed [DATA_W-1:0] d,
		input logic l);
		word_t w;
		w.status = st;
		w.data = d;
		w.last = l;
		fresh_words.push_back(w);
	endtask

	task automatic deque_apply(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v);
		int unsigned c;
		int unsigned f;
		int unsigned r;
		int unsigned i;
		fresh_words.delete();
		c = (cap_reg == 0) ? 1 : cap_reg;
		if (c > DEPTH)
			c = DEPTH;
		if (c > MAX_RESULTS)
			c = MAX_RESULTS;
		f = head;
		r = tail;
		case (k)
			KIND_PUSH_REAR, KIND_PUSH_FRONT: begin
				if (k == KIND_PUSH_FRONT && mode == MODE_INPUT_RESTRICTED) begin
					add_word(ST_REFUSED, '0, 1'b1);
				end else if (fill >= c) begin
					add_word(ST_OVERFLOW, '0, 1'b1);
				end else begin
					if (fill == 0) begin
						head = 0;
						tail = 0;
						ring[0] = v;
					end else if (k == KIND_PUSH_REAR) begin
						tail = (r + 1 >= c) ? 0 : r + 1;
						ring[tail] = v;
					end else begin
						head = (f == 0) ? c - 1 : f - 1;
						ring[head] = v;
					end
					fill++;
					add_word(ST_OK, '0, 1'b1);
				end
			end
			KIND_POP_FRONT, KIND_POP_REAR: begin
				if (k == KIND_POP_REAR && mode == MODE_OUTPUT_RESTRICTED) begin
					add_word(ST_REFUSED, '0, 1'b1);
				end else if (fill == 0) begin
					add_word(ST_UNDERFLOW, '0, 1'b1);
				end else begin
					if (k == KIND_POP_FRONT) begin
						add_word(ST_OK, ring[f], 1'b1);
						head = (f + 1 >= c) ? 0 : f + 1;
					end else begin
						add_word(ST_OK, ring[r], 1'b1);
						tail = (r == 0) ? c - 1 : r - 1;
					end
					fill--;
					if (fill == 0) begin
						head = 0;
						tail = 0;
					end
				end
			end
			KIND_DISPLAY: begin
				if (fill == 0) begin
					add_word(ST_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < fill && i < MAX_RESULTS; i++) begin
						add_word(ST_OK, ring[f], i + 1 == fill);
						f = (f + 1 >= c) ? 0 : f + 1;
					end
				end
			end
			default: begin
				add_word(ST_REFUSED, '0, 1'b1);
			end
		endcase
	endtask

	// hold the word on the ports until the block takes it
	task automatic issue(input logic [KIND_W-1:0] k, input logic signed [DATA_W-1:0] v,
		input logic typed, input word_t typed_w);
		start <= 1'b1;
		kind <= k;
		push_value <= v;
		do
			@(posedge clk);
		while (busy);
		deque_apply(k, v);
		if (typed)
			pending_words.push_back(typed_w);
		else
			foreach (fresh_words[i])
				pending_words.push_back(fresh_words[i]);
	endtask

	task automatic pause(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [CAP_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_RESTRICT_MODE) begin
			mode = val[0];
		end else begin
			cap_reg = val;
			head = 0;
			tail = 0;
			fill = 0;
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin : result_check
		word_t w;
		if (arst_n && done) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word status=%0d data=%0d last=%0b",
					status, data_value, last));
			end else begin
				w = pending_words.pop_front();
				if (status !== w.status || data_value !== w.data || last !== w.last)
					report_mismatch($sformatf("got status=%0d data=%0d last=%0b, want %0d %0d %0b",
						status, data_value, last, w.status, w.data, w.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("restricted_circular_deque_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		int r;
		int bias;
		logic [KIND_W-1:0] k;
		logic signed [DATA_W-1:0] v;
		logic [CAP_W-1:0] cap_v;
		row_t row;

		arst_n <= 1'b0;
		start <= 1'b0;
		kind <= KIND_PUSH_REAR;
		push_value <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RESTRICT_MODE;
		cfg_data <= '0;
		head = 0;
		tail = 0;
		fill = 0;
		mode = MODE_INPUT_RESTRICTED;
		cap_reg = CAP_W'(MAX_RESULTS);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			row = PLAN[i];
			if (row.act == ROW_REG)
				set_reg(row.reg_idx, row.value[CAP_W-1:0]);
			else
				issue(row.kind, row.value, row.typed, row.w);
		end

		for (int p = 0; p < PHASES; p++) begin
			set_reg(REG_RESTRICT_MODE, CAP_W'($urandom_range(0, 1) ? MODE_OUTPUT_RESTRICTED
				: MODE_INPUT_RESTRICTED));
			// first two phases fill a full-size ring and wrap it; mode changes keep contents
			if (p == 0) begin
				set_reg(REG_CAPACITY, CAP_W'(MAX_RESULTS));
				bias = 90;
			end else if (p == 1) begin
				bias = 90;
			end else begin
				if ($urandom_range(0, 2) != 0) begin
					r = $urandom_range(0, 9);
					if (r == 0)
						cap_v = '0;
					else if (r == 1)
						cap_v = CAP_W'(MAX_RESULTS);
					else if (r == 2)
						cap_v = CAP_W'($urandom_range(MAX_RESULTS + 1, (1 << CAP_W) - 1));
					else
						cap_v = CAP_W'($urandom_range(1, 8));
					set_reg(REG_CAPACITY, cap_v);
				end
				r = $urandom_range(0, 2);
				bias = (r == 0) ? 15 : (r == 1) ? 45 : 75;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p != QUIET_PHASE && $urandom_range(0, 99) < 4)
					pause($urandom_range(1, 4));
				r = $urandom_range(0, 99);
				if (r < 3)
					k = KIND_W'($urandom_range(KIND_BAD_LO, KIND_BAD_HI));
				else if (r < 18)
					k = KIND_DISPLAY;
				else if ($urandom_range(1, 100) <= bias)
					k = $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
				else
					k = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_REAR;
				r = $urandom_range(0, 9);
				if (r == 0)
					v = 32'sh7fff_ffff;
				else if (r == 1)
					v = 32'sh8000_0000;
				else
					v = $urandom;
				issue(k, v, 1'b0, NO_WORD);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("restricted_circular_deque_tb: clean");
		else
			$display("restricted_circular_deque_tb: errors");
		$finish;
	end

endmodule
